/* rtl/poi_pkg.sv */
`default_nettype none
package poi_pkg;

    localparam int POS_W      = 48;
    localparam int HEAD_W     = 44;
    localparam int SPEED_W    = 16;
    localparam int YAW_W      = 24;
    localparam int DT_W       = 21;
    localparam int QUAT_W     = 16;
    localparam int ANG_W      = 32;
    localparam int CS_W       = 34;
    localparam int MUL_A_W    = 40;
    localparam int MUL_B_W    = 22;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MOT_W      = 49;
    localparam int TRN_W      = MOT_W - 10;
    localparam int DELTA_W    = MUL_P_W - 20;
    localparam int SUM_W      = POS_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = POS_W;
    localparam int ATAN_IDX_W = 5;
    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 176;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;

    localparam logic signed [CS_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CS_W-1:0] QUARTER  = 34'sd1073741824;
    localparam logic signed [CS_W-1:0] HALF     = 34'sd2147483648;

    localparam logic signed [POS_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 48'sh8000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_MX1,
        ST_MX2,
        ST_MX3,
        ST_TX,
        ST_ADDX,
        ST_MY1,
        ST_MY2,
        ST_MY3,
        ST_TY,
        ST_ADDY,
        ST_HD,
        ST_HADD,
        ST_QUAT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } sincos_t;

    function automatic logic signed [CS_W-1:0] atan_at(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CS_W-1:0] r;
        unique case (idx)
            5'd0:    r = 34'sh020000000;
            5'd1:    r = 34'sh012E4051E;
            5'd2:    r = 34'sh009FB385B;
            5'd3:    r = 34'sh0051111D4;
            5'd4:    r = 34'sh0028B0D43;
            5'd5:    r = 34'sh00145D7E1;
            5'd6:    r = 34'sh000A2F61E;
            5'd7:    r = 34'sh000517C55;
            5'd8:    r = 34'sh00028BE53;
            5'd9:    r = 34'sh000145F2F;
            5'd10:   r = 34'sh0000A2F98;
            5'd11:   r = 34'sh0000517CC;
            5'd12:   r = 34'sh000028BE6;
            5'd13:   r = 34'sh0000145F3;
            5'd14:   r = 34'sh00000A2FA;
            5'd15:   r = 34'sh00000517D;
            5'd16:   r = 34'sh0000028BE;
            5'd17:   r = 34'sh00000145F;
            5'd18:   r = 34'sh000000A30;
            5'd19:   r = 34'sh000000518;
            5'd20:   r = 34'sh00000028C;
            5'd21:   r = 34'sh000000146;
            5'd22:   r = 34'sh0000000A3;
            5'd23:   r = 34'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/poi_cordic.sv */
`default_nettype none
module poi_cordic #(
    parameter int STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [poi_pkg::ANG_W-1:0] angle,
    output logic                           done,
    output poi_pkg::sincos_t               result
);
    import poi_pkg::*;

    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                   busy_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic [STEP_W-1:0]      step_reg;
    logic signed [CS_W-1:0] x_reg;
    logic signed [CS_W-1:0] y_reg;
    logic signed [CS_W-1:0] z_reg;
    sincos_t                res_reg;

    logic signed [ANG_W-1:0] ang_s;
    logic signed [CS_W-1:0]  ang_ext;
    logic signed [CS_W-1:0]  z_start;
    logic                    neg_start;
    logic signed [CS_W-1:0]  dx;
    logic signed [CS_W-1:0]  dy;
    logic signed [CS_W-1:0]  theta;
    logic signed [CS_W-1:0]  x_new;
    logic signed [CS_W-1:0]  y_new;
    logic signed [CS_W-1:0]  z_new;
    logic                    last;

    // fold into the right half plane, flip the signs afterwards
    always_comb begin
        ang_s     = signed'(angle);
        ang_ext   = CS_W'(ang_s);
        z_start   = ang_ext;
        neg_start = 1'b0;
        if (ang_ext > QUARTER) begin
            z_start   = ang_ext - HALF;
            neg_start = 1'b1;
        end else if (ang_ext < -QUARTER) begin
            z_start   = ang_ext + HALF;
            neg_start = 1'b1;
        end
    end

    always_comb begin
        dx    = y_reg >>> step_reg;
        dy    = x_reg >>> step_reg;
        theta = atan_at(ATAN_IDX_W'(step_reg));
        if (!z_reg[CS_W-1]) begin
            x_new = x_reg - dx;
            y_new = y_reg + dy;
            z_new = z_reg - theta;
        end else begin
            x_new = x_reg + dx;
            y_new = y_reg - dy;
            z_new = z_reg + theta;
        end
        last = (step_reg == STEP_W'(STEPS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            x_reg    <= GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= z_start;
            neg_reg  <= neg_start;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            x_reg    <= x_new;
            y_reg    <= y_new;
            z_reg    <= z_new;
            if (last) begin
                res_reg.cos_v <= neg_reg ? -x_new : x_new;
                res_reg.sin_v <= neg_reg ? -y_new : y_new;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

/* rtl/poi_mul.sv */
`default_nettype none
module poi_mul (
    input  wire logic                               aclk,
    input  wire logic signed [poi_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [poi_pkg::MUL_B_W-1:0] b,
    output logic signed [poi_pkg::MUL_P_W-1:0]      p
);
    import poi_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* rtl/planar_odometry_integrator.sv */
// one word is in work at a time: s_tready is high only in the idle state, so the next
// word is taken after the last has gone through two passes of the shared cordic unit,
// twelve steps through the one shared multiplier and the output load, which waits while
// a full output register is not taken; the accept cycle starts the first cordic pass
// a finished result waits in the output register while the next word is taken
// reset: synchronous active-low aresetn, pose and heading cleared to zero
`default_nettype none
module planar_odometry_integrator #(
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // forward_speed, side_speed, yaw_rate, elapsed
    input  wire logic [poi_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, heading, quat_z, quat_w
    output logic [poi_pkg::M_DATA_W-1:0]        m_tdata,
    // saturated
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_we,
    input  wire logic [poi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [poi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import poi_pkg::*;

    state_t state_reg, state_next;

    logic signed [SPEED_W-1:0] vx_reg;
    logic signed [SPEED_W-1:0] vy_reg;
    logic signed [YAW_W-1:0]   wz_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [POS_W-1:0]   x_reg;
    logic signed [POS_W-1:0]   y_reg;
    logic [HEAD_W-1:0]         heading_reg;
    logic signed [MOT_W-1:0]   acc_reg;
    logic signed [TRN_W-1:0]   t_reg;
    logic                      clip_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg;
    logic                      m_tuser_reg;
    logic                      m_tvalid_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      cordic_start;
    logic [ANG_W-1:0]          cordic_angle;
    logic                      cordic_done;
    sincos_t                   cs;

    logic                      in_acc;
    logic                      out_load;
    logic signed [MOT_W-1:0]   p_sum;
    logic signed [MOT_W-1:0]   p_rnd;
    logic signed [TRN_W-1:0]   t_new;
    logic signed [MUL_P_W-1:0] d_rnd;
    logic signed [DELTA_W-1:0] delta;
    logic signed [POS_W-1:0]   pos_sel;
    logic signed [SUM_W-1:0]   pos_sum;
    logic signed [POS_W-1:0]   pos_sat;
    logic                      clip_now;
    logic [HEAD_W-1:0]         heading_sum;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_w;

    function automatic logic signed [QUAT_W-1:0] to_q15(input logic signed [CS_W-1:0] v);
        logic signed [CS_W-1:0]    r;
        logic signed [CS_W-16:0]   q;
        logic signed [QUAT_W-1:0]  o;
        r = v + CS_W'(16384);
        q = r[CS_W-1:15];
        if (q > (CS_W-15)'(32767)) begin
            o = 16'sh7FFF;
        end else if (q < -(CS_W-15)'(32768)) begin
            o = 16'sh8000;
        end else begin
            o = q[QUAT_W-1:0];
        end
        return o;
    endfunction

    poi_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .result  (cs)
    );

    poi_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // shared multiplier operand select
    always_comb begin
        mul_a = MUL_A_W'(cs.cos_v);
        mul_b = MUL_B_W'(vx_reg);
        case (state_reg)
            ST_MX2: begin
                mul_a = MUL_A_W'(cs.sin_v);
                mul_b = MUL_B_W'(vy_reg);
            end
            ST_MY1: begin
                mul_a = MUL_A_W'(cs.sin_v);
                mul_b = MUL_B_W'(vx_reg);
            end
            ST_MY2: begin
                mul_a = MUL_A_W'(cs.cos_v);
                mul_b = MUL_B_W'(vy_reg);
            end
            ST_TX, ST_TY: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'({1'b0, dt_reg});
            end
            ST_HD: begin
                mul_a = MUL_A_W'(wz_reg);
                mul_b = MUL_B_W'({1'b0, dt_reg});
            end
            default: begin
                mul_a = MUL_A_W'(cs.cos_v);
                mul_b = MUL_B_W'(vx_reg);
            end
        endcase
    end

    always_comb begin
        if (state_reg == ST_MX3) begin
            p_sum = acc_reg - mul_p[MOT_W-1:0];
        end else begin
            p_sum = acc_reg + mul_p[MOT_W-1:0];
        end
        p_rnd = p_sum + MOT_W'(512);
        t_new = p_rnd[MOT_W-1:10];

        d_rnd = mul_p + MUL_P_W'(524288);
        delta = d_rnd[MUL_P_W-1:20];

        pos_sel  = (state_reg == ST_ADDX) ? x_reg : y_reg;
        pos_sum  = SUM_W'(pos_sel) + SUM_W'(delta);
        clip_now = 1'b0;
        if (pos_sum > SUM_W'(POS_MAX)) begin
            pos_sat  = POS_MAX;
            clip_now = 1'b1;
        end else if (pos_sum < SUM_W'(POS_MIN)) begin
            pos_sat  = POS_MIN;
            clip_now = 1'b1;
        end else begin
            pos_sat = pos_sum[POS_W-1:0];
        end

        heading_sum = heading_reg + mul_p[HEAD_W-1:0];

        quat_z = to_q15(cs.sin_v);
        quat_w = to_q15(cs.cos_v);
    end

    always_comb begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        cordic_angle = heading_reg[HEAD_W-1:HEAD_W-ANG_W];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cordic_start = 1'b1;
                    state_next   = ST_ROT;
                end
            end
            ST_ROT: begin
                if (cordic_done) begin
                    state_next = ST_MX1;
                end
            end
            ST_MX1:  state_next = ST_MX2;
            ST_MX2:  state_next = ST_MX3;
            ST_MX3:  state_next = ST_TX;
            ST_TX:   state_next = ST_ADDX;
            ST_ADDX: state_next = ST_MY1;
            ST_MY1:  state_next = ST_MY2;
            ST_MY2:  state_next = ST_MY3;
            ST_MY3:  state_next = ST_TY;
            ST_TY:   state_next = ST_ADDY;
            ST_ADDY: state_next = ST_HD;
            ST_HD:   state_next = ST_HADD;
            ST_HADD: begin
                // half angle of the new heading
                cordic_start = 1'b1;
                cordic_angle = {1'b0, heading_sum[HEAD_W-1:HEAD_W-ANG_W+1]};
                state_next   = ST_QUAT;
            end
            ST_QUAT: begin
                if (cordic_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= '0;
            y_reg        <= '0;
            heading_reg  <= '0;
            clip_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_START_X:       x_reg       <= cfg_wdata[POS_W-1:0];
                    CFG_START_Y:       y_reg       <= cfg_wdata[POS_W-1:0];
                    CFG_START_HEADING: heading_reg <= cfg_wdata[HEAD_W-1:0];
                    default: ;
                endcase
            end else if (state_reg == ST_ADDX) begin
                x_reg <= pos_sat;
            end else if (state_reg == ST_ADDY) begin
                y_reg <= pos_sat;
            end else if (state_reg == ST_HADD) begin
                heading_reg <= heading_sum;
            end

            if (in_acc) begin
                clip_reg <= 1'b0;
            end else if ((state_reg == ST_ADDX || state_reg == ST_ADDY) && clip_now) begin
                clip_reg <= 1'b1;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            vx_reg <= s_tdata[15:0];
            vy_reg <= s_tdata[31:16];
            wz_reg <= s_tdata[55:32];
            dt_reg <= s_tdata[76:56];
        end
        if (state_reg == ST_MX2 || state_reg == ST_MY2) begin
            acc_reg <= mul_p[MOT_W-1:0];
        end
        if (state_reg == ST_MX3 || state_reg == ST_MY3) begin
            t_reg <= t_new;
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0000, quat_w, quat_z, heading_reg, y_reg, x_reg};
            m_tuser_reg <= clip_reg;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> state_reg == ST_ROT)
        else $error("accepted word did not start the heading rotation");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_ROT || state_reg == ST_QUAT))
        else $error("cordic finished outside a waiting state");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[47:0] == POS_MAX || m_tdata[47:0] == POS_MIN ||
             m_tdata[95:48] == POS_MAX || m_tdata[95:48] == POS_MIN))
        else $error("saturated result without a position at its limit");

    a_heading_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(heading_reg) |-> ($past(state_reg) == ST_HADD || $past(cfg_we)))
        else $error("heading changed outside its update step");

endmodule
`default_nettype wire
